[rtl/core/rmt_pkg.sv]
// shared types, widths and helpers for the ray midpoint triangulation block
package rmt_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // product of a word and a difference of two words
    localparam int PROD_W    = 2 * WORD_BITS + 1;
    // dot products of three terms, with room for a negation
    localparam int DOT_W     = 2 * WORD_BITS + 4;
    // wide multiplier
    localparam int MUL_IN_W  = DOT_W;
    localparam int MUL_OUT_W = 2 * MUL_IN_W;
    localparam int LIMB_W    = (MUL_IN_W + 2) / 3;
    localparam int MUL_LAT   = 5;
    // determinant and numerators
    localparam int SUM_W     = MUL_OUT_W + 1;
    // divider
    localparam int DIV_R_W   = SUM_W + WORD_BITS;
    localparam int DIV_LAT   = WORD_BITS + 2;
    // closest points and their differences
    localparam int PT_W      = WORD_BITS + FRAC_BITS + 2;
    // sum of squared differences and square root
    localparam int SQ_SUM_W  = MUL_OUT_W + 2;
    localparam int SQRT_R_W  = WORD_BITS + 3;
    localparam int SQRT_LAT  = WORD_BITS + 2;
    // queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic signed [WORD_BITS-1:0] S_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] S_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [WORD_BITS-1:0] dir_a_x;
        logic signed [WORD_BITS-1:0] dir_a_y;
        logic signed [WORD_BITS-1:0] dir_a_z;
        logic signed [WORD_BITS-1:0] orig_a_x;
        logic signed [WORD_BITS-1:0] orig_a_y;
        logic signed [WORD_BITS-1:0] orig_a_z;
        logic signed [WORD_BITS-1:0] dir_b_x;
        logic signed [WORD_BITS-1:0] dir_b_y;
        logic signed [WORD_BITS-1:0] dir_b_z;
        logic signed [WORD_BITS-1:0] orig_b_x;
        logic signed [WORD_BITS-1:0] orig_b_y;
        logic signed [WORD_BITS-1:0] orig_b_z;
    } in_word_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] mid_x;
        logic signed [WORD_BITS-1:0] mid_y;
        logic signed [WORD_BITS-1:0] mid_z;
        logic        [WORD_BITS-1:0] gap;
        logic signed [WORD_BITS-1:0] param_a;
        logic signed [WORD_BITS-1:0] param_b;
        logic                        degenerate;
    } out_word_t;

    // classified ray pair handed from front to back
    typedef struct packed {
        logic signed [SUM_W-1:0] det;
        logic signed [SUM_W-1:0] num_a;
        logic signed [SUM_W-1:0] num_b;
        logic                    degen;
        in_word_t                ray;
    } job_t;

    // signed product of two words extended by one bit
    function automatic logic signed [PROD_W-1:0] smul(input logic signed [WORD_BITS:0] x,
                                                      input logic signed [WORD_BITS:0] y);
        return PROD_W'(x) * PROD_W'(y);
    endfunction

    // saturate a point sum to the signed word range
    function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [PT_W:0] x);
        if (x > (PT_W+1)'(S_MAX))
            return S_MAX;
        else if (x < (PT_W+1)'(S_MIN))
            return S_MIN;
        else
            return WORD_BITS'(x);
    endfunction

endpackage

[rtl/core/rmt_mul.sv]
// pipelined signed wide multiplier built from three by three limb products
module rmt_mul
    import rmt_pkg::*;
(
    input  logic                        clk,
    input  logic signed [MUL_IN_W-1:0]  x,
    input  logic signed [MUL_IN_W-1:0]  y,
    output logic signed [MUL_OUT_W-1:0] p
);

    localparam int LIMB3_W = 3 * LIMB_W;
    localparam int PP_W    = 2 * LIMB_W;
    localparam int DIAG_W  = PP_W + 2;
    localparam int MAG_W   = 6 * LIMB_W;

    logic               neg_reg [4];
    logic [LIMB3_W-1:0] xm_reg;
    logic [LIMB3_W-1:0] ym_reg;
    logic [PP_W-1:0]    pp_reg [3][3];
    logic [DIAG_W-1:0]  diag_reg [5];
    logic [DIAG_W-1:0]  diag_next [5];
    logic [MAG_W-1:0]   mag_reg;
    logic [MAG_W-1:0]   mag_next;
    logic signed [MUL_OUT_W-1:0] p_reg;

    // diagonal sums of equal weight
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            diag_next[k] = '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (i + j == k)
                        diag_next[k] = diag_next[k] + DIAG_W'(pp_reg[i][j]);
                end
            end
        end
    end

    // weighted sum of the diagonals
    always_comb
    begin
        mag_next = '0;
        for (int k = 0; k < 5; k++)
            mag_next = mag_next + (MAG_W'(diag_reg[k]) << (k * LIMB_W));
    end

    // magnitudes, limb products, diagonals, magnitude, sign
    always_ff @(posedge clk)
    begin
        neg_reg[0] <= x[MUL_IN_W-1] ^ y[MUL_IN_W-1];
        xm_reg     <= LIMB3_W'(x[MUL_IN_W-1] ? MUL_IN_W'(-x) : MUL_IN_W'(x));
        ym_reg     <= LIMB3_W'(y[MUL_IN_W-1] ? MUL_IN_W'(-y) : MUL_IN_W'(y));
        for (int k = 1; k < 4; k++)
            neg_reg[k] <= neg_reg[k-1];
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                pp_reg[i][j] <= PP_W'(xm_reg[i*LIMB_W +: LIMB_W]) *
                                PP_W'(ym_reg[j*LIMB_W +: LIMB_W]);
        end
        for (int k = 0; k < 5; k++)
            diag_reg[k] <= diag_next[k];
        mag_reg <= mag_next;
        p_reg   <= neg_reg[3] ? MUL_OUT_W'(-mag_reg) : MUL_OUT_W'(mag_reg);
    end

    assign p = p_reg;

endmodule

[rtl/core/rmt_div.sv]
// pipelined signed divider, one quotient bit a stage, result saturated to a word
module rmt_div
    import rmt_pkg::*;
(
    input  logic                        clk,
    input  logic signed [SUM_W-1:0]     num,
    input  logic signed [SUM_W-1:0]     den,
    output logic signed [WORD_BITS-1:0] quo
);

    localparam int QB = WORD_BITS - 1;

    logic [SUM_W-1:0]   na_reg;
    logic [SUM_W-1:0]   da_reg;
    logic               nega_reg;
    logic [DIV_R_W-1:0] rem_reg [WORD_BITS];
    logic [DIV_R_W-1:0] d_reg   [WORD_BITS];
    logic [QB-1:0]      q_reg   [WORD_BITS];
    logic               neg_reg [WORD_BITS];
    logic               ovf_reg [WORD_BITS];
    logic signed [WORD_BITS-1:0] quo_reg;
    logic [DIV_R_W-1:0] rem_first;

    // magnitudes and sign of the quotient
    always_ff @(posedge clk)
    begin
        nega_reg <= num[SUM_W-1] ^ den[SUM_W-1];
        na_reg   <= num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
        da_reg   <= den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
    end

    // scaled numerator and overflow check against the word range
    assign rem_first = DIV_R_W'(na_reg) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_first;
        d_reg[0]   <= DIV_R_W'(da_reg);
        q_reg[0]   <= '0;
        neg_reg[0] <= nega_reg;
        ovf_reg[0] <= rem_first >= (DIV_R_W'(da_reg) << QB);
    end

    // one quotient bit a stage, most significant first
    for (genvar k = 0; k < QB; k++)
    begin : g_bit
        logic [DIV_R_W-1:0] trial;
        logic               take;

        always_comb
        begin
            trial = d_reg[k] << (QB - 1 - k);
            take  = rem_reg[k] >= trial;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= take ? rem_reg[k] - trial : rem_reg[k];
            q_reg[k+1]   <= {q_reg[k][QB-2:0], take};
            d_reg[k+1]   <= d_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    // sign and saturation
    always_ff @(posedge clk)
    begin
        if (ovf_reg[QB])
            quo_reg <= neg_reg[QB] ? S_MIN : S_MAX;
        else if (neg_reg[QB])
            quo_reg <= -WORD_BITS'(q_reg[QB]);
        else
            quo_reg <= WORD_BITS'(q_reg[QB]);
    end

    assign quo = quo_reg;

endmodule

[rtl/core/rmt_sqrt.sv]
// pipelined integer square root, one root bit a stage, result saturated to a word
module rmt_sqrt
    import rmt_pkg::*;
(
    input  logic                 clk,
    input  logic [SQ_SUM_W-1:0]  rad,
    output logic [WORD_BITS-1:0] root
);

    localparam int N_W = 2 * WORD_BITS;

    logic [SQRT_R_W-1:0]  rem_reg  [WORD_BITS+1];
    logic [WORD_BITS-1:0] root_reg [WORD_BITS+1];
    logic [N_W-1:0]       n_reg    [WORD_BITS+1];
    logic                 ovf_reg  [WORD_BITS+1];
    logic [WORD_BITS-1:0] out_reg;

    // radicand beyond the word range saturates
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        n_reg[0]    <= rad[N_W-1:0];
        ovf_reg[0]  <= rad[SQ_SUM_W-1:N_W] != '0;
    end

    // two radicand bits in, one root bit out per stage
    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_bit
        logic [SQRT_R_W-1:0] cur;
        logic [SQRT_R_W-1:0] trial;
        logic                take;

        always_comb
        begin
            cur   = {rem_reg[k][SQRT_R_W-3:0], n_reg[k][N_W-1 -: 2]};
            trial = SQRT_R_W'({root_reg[k], 2'b01});
            take  = cur >= trial;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= take ? cur - trial : cur;
            root_reg[k+1] <= {root_reg[k][WORD_BITS-2:0], take};
            n_reg[k+1]    <= n_reg[k] << 2;
            ovf_reg[k+1]  <= ovf_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= ovf_reg[WORD_BITS] ? '1 : root_reg[WORD_BITS];
    end

    assign root = out_reg;

endmodule

[rtl/core/rmt_queue.sv]
// short queue of classified ray pairs between front and back
module rmt_queue
    import rmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    input  logic pop,
    output job_t dout,
    output logic empty,
    output logic full
);

    job_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign empty   = count_reg == '0;
    assign full    = count_reg == (Q_AW+1)'(Q_DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

[rtl/core/rmt_front.sv]
// front: dot products, determinant, numerators and the degenerate check
module rmt_front
    import rmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_word_t in_word,
    output logic     job_valid,
    output job_t     job
);

    localparam int DLY = MUL_LAT + 2;

    logic                        v1_reg;
    in_word_t                    w1_reg;
    logic signed [WORD_BITS:0]   e1_reg [3];
    logic signed [WORD_BITS-1:0] va [3];
    logic signed [WORD_BITS-1:0] vb [3];
    logic signed [PROD_W-1:0]    aa_reg [3];
    logic signed [PROD_W-1:0]    ab_reg [3];
    logic signed [PROD_W-1:0]    bb_reg [3];
    logic signed [PROD_W-1:0]    ae_reg [3];
    logic signed [PROD_W-1:0]    be_reg [3];
    logic signed [DOT_W-1:0]     a_reg;
    logic signed [DOT_W-1:0]     b_reg;
    logic signed [DOT_W-1:0]     c_reg;
    logic signed [DOT_W-1:0]     q1_reg;
    logic signed [DOT_W-1:0]     q2_reg;
    logic signed [MUL_OUT_W-1:0] ac;
    logic signed [MUL_OUT_W-1:0] bsq;
    logic signed [MUL_OUT_W-1:0] cq1;
    logic signed [MUL_OUT_W-1:0] bq2;
    logic signed [MUL_OUT_W-1:0] bq1;
    logic signed [MUL_OUT_W-1:0] aq2;
    in_word_t                    dly_reg [DLY];
    logic                        vdly_reg [DLY];
    logic signed [SUM_W-1:0]     det_next;
    job_t                        job_reg;
    logic                        job_valid_reg;

    // valid bits along the front
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            for (int k = 0; k < DLY; k++)
                vdly_reg[k] <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg      <= in_valid;
            vdly_reg[0] <= v1_reg;
            for (int k = 1; k < DLY; k++)
                vdly_reg[k] <= vdly_reg[k-1];
            job_valid_reg <= vdly_reg[DLY-1];
        end
    end

    // capture word and origin differences
    always_ff @(posedge clk)
    begin
        w1_reg    <= in_word;
        e1_reg[0] <= (WORD_BITS+1)'(in_word.orig_b_x) - (WORD_BITS+1)'(in_word.orig_a_x);
        e1_reg[1] <= (WORD_BITS+1)'(in_word.orig_b_y) - (WORD_BITS+1)'(in_word.orig_a_y);
        e1_reg[2] <= (WORD_BITS+1)'(in_word.orig_b_z) - (WORD_BITS+1)'(in_word.orig_a_z);
    end

    always_comb
    begin
        va[0] = w1_reg.dir_a_x;
        va[1] = w1_reg.dir_a_y;
        va[2] = w1_reg.dir_a_z;
        vb[0] = w1_reg.dir_b_x;
        vb[1] = w1_reg.dir_b_y;
        vb[2] = w1_reg.dir_b_z;
    end

    // component products, then dot products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            aa_reg[i] <= smul(va[i], va[i]);
            ab_reg[i] <= smul(va[i], vb[i]);
            bb_reg[i] <= smul(vb[i], vb[i]);
            ae_reg[i] <= smul(va[i], e1_reg[i]);
            be_reg[i] <= smul(vb[i], e1_reg[i]);
        end
        a_reg  <= DOT_W'(aa_reg[0]) + DOT_W'(aa_reg[1]) + DOT_W'(aa_reg[2]);
        b_reg  <= DOT_W'(ab_reg[0]) + DOT_W'(ab_reg[1]) + DOT_W'(ab_reg[2]);
        c_reg  <= DOT_W'(bb_reg[0]) + DOT_W'(bb_reg[1]) + DOT_W'(bb_reg[2]);
        q1_reg <= DOT_W'(ae_reg[0]) + DOT_W'(ae_reg[1]) + DOT_W'(ae_reg[2]);
        q2_reg <= -(DOT_W'(be_reg[0]) + DOT_W'(be_reg[1]) + DOT_W'(be_reg[2]));
    end

    // wide products of the normal equations
    rmt_mul u_mul_ac  (.clk(clk), .x(a_reg), .y(c_reg),  .p(ac));
    rmt_mul u_mul_bb  (.clk(clk), .x(b_reg), .y(b_reg),  .p(bsq));
    rmt_mul u_mul_cq1 (.clk(clk), .x(c_reg), .y(q1_reg), .p(cq1));
    rmt_mul u_mul_bq2 (.clk(clk), .x(b_reg), .y(q2_reg), .p(bq2));
    rmt_mul u_mul_bq1 (.clk(clk), .x(b_reg), .y(q1_reg), .p(bq1));
    rmt_mul u_mul_aq2 (.clk(clk), .x(a_reg), .y(q2_reg), .p(aq2));

    // ray words ride along with the products
    always_ff @(posedge clk)
    begin
        dly_reg[0] <= w1_reg;
        for (int k = 1; k < DLY; k++)
            dly_reg[k] <= dly_reg[k-1];
    end

    assign det_next = SUM_W'(ac) - SUM_W'(bsq);

    // determinant, numerators and classification
    always_ff @(posedge clk)
    begin
        job_reg.det   <= det_next;
        job_reg.num_a <= SUM_W'(cq1) + SUM_W'(bq2);
        job_reg.num_b <= SUM_W'(bq1) + SUM_W'(aq2);
        job_reg.degen <= det_next == '0;
        job_reg.ray   <= dly_reg[DLY-1];
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

[rtl/core/rmt_back.sv]
// back: ray parameters, closest points, midpoint and gap
module rmt_back
    import rmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    output logic      done,
    output out_word_t result
);

    typedef struct packed {
        logic signed [WORD_BITS-1:0] mid_x;
        logic signed [WORD_BITS-1:0] mid_y;
        logic signed [WORD_BITS-1:0] mid_z;
        logic signed [WORD_BITS-1:0] la;
        logic signed [WORD_BITS-1:0] lb;
        logic                        degen;
    } tail_t;

    logic                        jv_reg;
    job_t                        jb_reg;
    logic signed [WORD_BITS-1:0] la;
    logic signed [WORD_BITS-1:0] lb;
    in_word_t                    ray_dly_reg [DIV_LAT];
    logic                        dg_dly_reg [DIV_LAT];
    logic                        v_dly_reg [DIV_LAT];
    in_word_t                    ray;
    logic signed [WORD_BITS-1:0] va [3];
    logic signed [WORD_BITS-1:0] vb [3];
    logic signed [WORD_BITS-1:0] oa [3];
    logic signed [WORD_BITS-1:0] ob [3];
    logic signed [PROD_W-1:0]    pra_reg [3];
    logic signed [PROD_W-1:0]    prb_reg [3];
    logic signed [WORD_BITS-1:0] oa1_reg [3];
    logic signed [WORD_BITS-1:0] ob1_reg [3];
    logic signed [WORD_BITS-1:0] la1_reg;
    logic signed [WORD_BITS-1:0] lb1_reg;
    logic                        dg1_reg;
    logic                        v1_reg;
    logic signed [PT_W-1:0]      pa_reg [3];
    logic signed [PT_W-1:0]      pb_reg [3];
    logic signed [WORD_BITS-1:0] la2_reg;
    logic signed [WORD_BITS-1:0] lb2_reg;
    logic                        dg2_reg;
    logic                        v2_reg;
    tail_t                       tail3_reg;
    logic signed [PT_W:0]        diff_reg [3];
    logic                        v3_reg;
    logic signed [MUL_OUT_W-1:0] sq [3];
    tail_t                       tm_dly_reg [MUL_LAT];
    logic                        vm_dly_reg [MUL_LAT];
    logic [SQ_SUM_W-1:0]         sum_reg;
    tail_t                       tail4_reg;
    logic                        v4_reg;
    logic [WORD_BITS-1:0]        gap;
    tail_t                       ts_dly_reg [SQRT_LAT];
    logic                        vs_dly_reg [SQRT_LAT];
    tail_t                       tl;
    out_word_t                   result_reg;
    logic                        done_reg;

    // valid bits along the back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jv_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
                v_dly_reg[k] <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k < MUL_LAT; k++)
                vm_dly_reg[k] <= 1'b0;
            v4_reg <= 1'b0;
            for (int k = 0; k < SQRT_LAT; k++)
                vs_dly_reg[k] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            jv_reg       <= job_valid;
            v_dly_reg[0] <= jv_reg;
            for (int k = 1; k < DIV_LAT; k++)
                v_dly_reg[k] <= v_dly_reg[k-1];
            v1_reg        <= v_dly_reg[DIV_LAT-1];
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vm_dly_reg[0] <= v3_reg;
            for (int k = 1; k < MUL_LAT; k++)
                vm_dly_reg[k] <= vm_dly_reg[k-1];
            v4_reg        <= vm_dly_reg[MUL_LAT-1];
            vs_dly_reg[0] <= v4_reg;
            for (int k = 1; k < SQRT_LAT; k++)
                vs_dly_reg[k] <= vs_dly_reg[k-1];
            done_reg <= vs_dly_reg[SQRT_LAT-1];
        end
    end

    // take the word from the queue
    always_ff @(posedge clk)
    begin
        jb_reg <= job;
    end

    // ray parameters
    rmt_div u_div_a (.clk(clk), .num(jb_reg.num_a), .den(jb_reg.det), .quo(la));
    rmt_div u_div_b (.clk(clk), .num(jb_reg.num_b), .den(jb_reg.det), .quo(lb));

    always_ff @(posedge clk)
    begin
        ray_dly_reg[0] <= jb_reg.ray;
        dg_dly_reg[0]  <= jb_reg.degen;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            ray_dly_reg[k] <= ray_dly_reg[k-1];
            dg_dly_reg[k]  <= dg_dly_reg[k-1];
        end
    end

    assign ray = ray_dly_reg[DIV_LAT-1];

    always_comb
    begin
        va[0] = ray.dir_a_x;
        va[1] = ray.dir_a_y;
        va[2] = ray.dir_a_z;
        vb[0] = ray.dir_b_x;
        vb[1] = ray.dir_b_y;
        vb[2] = ray.dir_b_z;
        oa[0] = ray.orig_a_x;
        oa[1] = ray.orig_a_y;
        oa[2] = ray.orig_a_z;
        ob[0] = ray.orig_b_x;
        ob[1] = ray.orig_b_y;
        ob[2] = ray.orig_b_z;
    end

    // parameter times direction, then closest points, then midpoint and difference
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pra_reg[i] <= smul(la, va[i]);
            prb_reg[i] <= smul(lb, vb[i]);
            oa1_reg[i] <= oa[i];
            ob1_reg[i] <= ob[i];
        end
        la1_reg <= la;
        lb1_reg <= lb;
        dg1_reg <= dg_dly_reg[DIV_LAT-1];

        for (int i = 0; i < 3; i++)
        begin
            pa_reg[i] <= PT_W'(pra_reg[i] >>> FRAC_BITS) + PT_W'(oa1_reg[i]);
            pb_reg[i] <= PT_W'(prb_reg[i] >>> FRAC_BITS) + PT_W'(ob1_reg[i]);
        end
        la2_reg <= la1_reg;
        lb2_reg <= lb1_reg;
        dg2_reg <= dg1_reg;

        tail3_reg.mid_x <= sat_word(((PT_W+1)'(pa_reg[0]) + (PT_W+1)'(pb_reg[0])) >>> 1);
        tail3_reg.mid_y <= sat_word(((PT_W+1)'(pa_reg[1]) + (PT_W+1)'(pb_reg[1])) >>> 1);
        tail3_reg.mid_z <= sat_word(((PT_W+1)'(pa_reg[2]) + (PT_W+1)'(pb_reg[2])) >>> 1);
        tail3_reg.la    <= la2_reg;
        tail3_reg.lb    <= lb2_reg;
        tail3_reg.degen <= dg2_reg;
        for (int i = 0; i < 3; i++)
            diff_reg[i] <= (PT_W+1)'(pb_reg[i]) - (PT_W+1)'(pa_reg[i]);
    end

    // squared differences
    for (genvar i = 0; i < 3; i++)
    begin : g_sq
        rmt_mul u_mul_sq (
            .clk(clk),
            .x(MUL_IN_W'(diff_reg[i])),
            .y(MUL_IN_W'(diff_reg[i])),
            .p(sq[i])
        );
    end

    // results ride along with the squares and the root
    always_ff @(posedge clk)
    begin
        tm_dly_reg[0] <= tail3_reg;
        for (int k = 1; k < MUL_LAT; k++)
            tm_dly_reg[k] <= tm_dly_reg[k-1];
        sum_reg   <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
        tail4_reg <= tm_dly_reg[MUL_LAT-1];
        ts_dly_reg[0] <= tail4_reg;
        for (int k = 1; k < SQRT_LAT; k++)
            ts_dly_reg[k] <= ts_dly_reg[k-1];
    end

    rmt_sqrt u_sqrt (.clk(clk), .rad(sum_reg), .root(gap));

    assign tl = ts_dly_reg[SQRT_LAT-1];

    // result word, zeros for parallel rays
    always_ff @(posedge clk)
    begin
        if (tl.degen)
        begin
            result_reg.mid_x      <= '0;
            result_reg.mid_y      <= '0;
            result_reg.mid_z      <= '0;
            result_reg.gap        <= '0;
            result_reg.param_a    <= '0;
            result_reg.param_b    <= '0;
            result_reg.degenerate <= 1'b1;
        end
        else
        begin
            result_reg.mid_x      <= tl.mid_x;
            result_reg.mid_y      <= tl.mid_y;
            result_reg.mid_z      <= tl.mid_z;
            result_reg.gap        <= gap;
            result_reg.param_a    <= tl.la;
            result_reg.param_b    <= tl.lb;
            result_reg.degenerate <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/core/ray_midpoint_triangulation_top.sv]
// top level of the two-ray midpoint triangulation block
//
// A ray pair word is taken on request when start is high and busy is low.
// Every accepted word yields exactly one result word on result, marked by
// done for a single cycle; the receiver cannot hold results off.
// Throughput is one ray pair per cycle, sustained while busy is low: every
// stage is pipelined. The path runs through the front (dot products and the
// wide multipliers of the normal equations), the queue, each parameter
// divider (one quotient bit a stage), closest points and squares, and the
// square root (one root bit a stage).
// The front classifies each pair (parallel rays have a zero determinant)
// and writes it to a two-entry queue; busy is high only while the queue is
// full, which the always-draining back never lets happen in steady use.
// Parallel rays give an all-zero result with degenerate set.
// Reset clears the valid bits and the queue; nothing else is held.
module ray_midpoint_triangulation_top
    import rmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  request,
    output logic      done,
    output out_word_t result
);

    logic front_valid;
    job_t front_job;
    job_t queue_job;
    logic queue_empty;
    logic queue_full;

    assign busy = queue_full;

    rmt_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(start && !busy),
        .in_word(request),
        .job_valid(front_valid),
        .job(front_job)
    );

    rmt_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(front_valid),
        .din(front_job),
        .pop(!queue_empty),
        .dout(queue_job),
        .empty(queue_empty),
        .full(queue_full)
    );

    rmt_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job_valid(!queue_empty),
        .job(queue_job),
        .done(done),
        .result(result)
    );

endmodule
